// ----- design/ngel_pkg.sv -----
// Shared types and constants of the next-greater-element unit.
`timescale 1ns / 1ps

package ngel_pkg;

   localparam int DATA_W      = 32;  // element and answer width
   localparam int MAX_LEN_DEF = 64;  // default sequence capacity

   typedef enum logic [2:0] {
      ST_LOAD,   // taking elements into the value store
      ST_FETCH,  // first read of the reverse scan
      ST_CMP,    // compare current element against the stack top
      ST_POPW,   // wait for the new stack top after a pop
      ST_EMIT    // stream answers out in arrival order
   } state_type;

endpackage

// ----- design/ngel_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ngel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next enabled read
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/next_greater_element_unit.sv -----
// Top level: next-greater-element unit built around value, answer and stack RAMs.
`timescale 1ns / 1ps

// Channel   Dir  tdata                  tlast        tuser
// req_      in   [31:0] value           is_final     -
// rsp_      out  [31:0] next_greater    end_of_run   [0] overflowed
//
// Flow: the run is loaded, then a reverse scan reads each element back and
// compares it with the cached stack top; each pop waits in ST_POPW for the stack
// RAM read data (at most n-1 pops for a run of n items); answers then stream out.
// Reset: synchronous, active high; clears control state only, RAMs untouched.
// Stalls: req_tready is low during scan and output; a stalled rsp_ holds its
// transaction and the answer read queued behind it.

module next_greater_element_unit #(
   parameter int MAX_LEN = ngel_pkg::MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_ stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ngel_pkg::DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                        req_tlast,   // is_final
   // rsp_ stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ngel_pkg::DATA_W-1:0] rsp_tdata,   // [31:0] next_greater
   output logic                        rsp_tlast,   // end_of_run
   output logic                        rsp_tuser    // [0] overflowed
);

   import ngel_pkg::*;

   localparam int AW = $clog2(MAX_LEN);      // RAM address width
   localparam int CW = $clog2(MAX_LEN + 1);  // counts up to MAX_LEN

   // control state
   state_type                state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;     // stored elements
   logic                     drop_ff, drop_in;   // capacity exceeded this run
   logic [CW-1:0]            i_ff, i_in;         // scan position
   logic [CW-1:0]            sd_ff, sd_in;       // stack depth
   logic [CW-1:0]            k_ff, k_in;         // emit read position
   logic                     pend_ff, pend_in;   // answer read data waiting
   logic                     plast_ff, plast_in; // waiting answer is the last
   logic                     rvld_ff, rvld_in;

   // payload
   logic signed [DATA_W-1:0] top_ff, top_in;     // cached stack top
   logic [DATA_W-1:0]        rdat_ff, rdat_in;
   logic                     rlast_ff, rlast_in;
   logic                     ruser_ff, ruser_in;

   // RAM ports
   logic              vs_we, vs_re, as_we, as_re, st_we, st_re;
   logic [AW-1:0]     vs_wa, vs_ra, as_wa, as_ra, st_wa, st_ra;
   logic [DATA_W-1:0] vs_rd, as_wd, as_rd, st_rd;

   logic signed [DATA_W-1:0] cur;
   logic [CW-1:0]            i_dec, sd_dec2, cnt_inc;
   logic                     load_out, issue, req_acc;

   assign cur      = vs_rd;
   assign i_dec    = i_ff - 1'b1;
   assign sd_dec2  = sd_ff - CW'(2);
   assign cnt_inc  = cnt_ff + 1'b1;
   assign req_acc  = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = rdat_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = ruser_ff;

   // answer read data moves to the output register when the slot frees up
   assign load_out = pend_ff && (!rvld_ff || rsp_tready);
   assign issue    = (state_ff == ST_EMIT) && (k_ff < cnt_ff) && (!pend_ff || load_out);

   ngel_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_value_ram (
      .clock   (clock),
      .wr_en   (vs_we),
      .wr_addr (vs_wa),
      .wr_data (req_tdata),
      .rd_en   (vs_re),
      .rd_addr (vs_ra),
      .rd_data (vs_rd)
   );

   ngel_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_answer_ram (
      .clock   (clock),
      .wr_en   (as_we),
      .wr_addr (as_wa),
      .wr_data (as_wd),
      .rd_en   (as_re),
      .rd_addr (as_ra),
      .rd_data (as_rd)
   );

   ngel_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wa),
      .wr_data (cur),
      .rd_en   (st_re),
      .rd_addr (st_ra),
      .rd_data (st_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         i_ff     <= '0;
         sd_ff    <= '0;
         k_ff     <= '0;
         pend_ff  <= 1'b0;
         plast_ff <= 1'b0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         i_ff     <= i_in;
         sd_ff    <= sd_in;
         k_ff     <= k_in;
         pend_ff  <= pend_in;
         plast_ff <= plast_in;
         rvld_ff  <= rvld_in;
      end
      top_ff   <= top_in;
      rdat_ff  <= rdat_in;
      rlast_ff <= rlast_in;
      ruser_ff <= ruser_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      i_in     = i_ff;
      sd_in    = sd_ff;
      k_in     = k_ff;
      pend_in  = pend_ff;
      plast_in = plast_ff;
      top_in   = top_ff;
      rvld_in  = rvld_ff && !rsp_tready;
      rdat_in  = rdat_ff;
      rlast_in = rlast_ff;
      ruser_in = ruser_ff;

      vs_we = 1'b0;
      vs_wa = cnt_ff[AW-1:0];
      vs_re = 1'b0;
      vs_ra = i_dec[AW-1:0];
      as_we = 1'b0;
      as_wa = i_ff[AW-1:0];
      as_wd = (sd_ff != '0) ? top_ff : '0;
      as_re = issue;
      as_ra = k_ff[AW-1:0];
      st_we = 1'b0;
      st_wa = sd_ff[AW-1:0];
      st_re = 1'b0;
      st_ra = sd_dec2[AW-1:0];

      // output register, shared by all states
      if (load_out) begin
         rvld_in  = 1'b1;
         rdat_in  = as_rd;
         rlast_in = plast_ff;
         ruser_in = drop_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (cnt_ff < CW'(MAX_LEN)) begin
                  vs_we  = 1'b1;
                  cnt_in = cnt_inc;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_FETCH;
                  i_in     = cnt_in;
                  sd_in    = '0;
               end
            end
         end
         ST_FETCH: begin
            vs_re    = 1'b1;
            i_in     = i_dec;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((sd_ff != '0) && !(top_ff > cur)) begin
               // pop; fetch the entry below unless the stack empties
               sd_in    = sd_ff - 1'b1;
               st_re    = (sd_ff > CW'(1));
               state_in = ST_POPW;
            end else begin
               as_we  = 1'b1;
               st_we  = 1'b1;
               sd_in  = sd_ff + 1'b1;
               top_in = cur;
               if (i_ff == '0) begin
                  state_in = ST_EMIT;
                  k_in     = '0;
                  pend_in  = 1'b0;
               end else begin
                  vs_re = 1'b1;
                  i_in  = i_dec;
               end
            end
         end
         ST_POPW: begin
            top_in   = st_rd;
            state_in = ST_CMP;
         end
         ST_EMIT: begin
            if (issue) begin
               k_in     = k_ff + 1'b1;
               pend_in  = 1'b1;
               plast_in = ((k_ff + 1'b1) == cnt_ff);
            end else if (load_out) begin
               pend_in = 1'b0;
            end
            if (load_out && plast_ff) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
               drop_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_LEN))
      else $error("element count beyond capacity");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (sd_ff <= cnt_ff))
      else $error("stack deeper than stored run");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (i_ff < cnt_ff))
      else $error("scan position outside stored run");

   a_pend_emit: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_EMIT))
      else $error("answer read pending outside output phase");
`endif

endmodule
